// ===== rtl/elol_pkg.sv =====
// shared types and constants for the edit list offset lookup
package elol_pkg;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	localparam logic       MODE_APPEND = 1'b0;
	localparam logic       MODE_FIND   = 1'b1;

	localparam logic [30:0] FRAME_MAX  = 31'h7fff_ffff;
	localparam logic [31:0] OFFSET_MAX = 32'hffff_ffff;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ENTRY,
		ST_LAST,
		ST_SRCH_RD,
		ST_SRCH_CMP
	} state_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_FULL,
		EMIT_MISS,
		EMIT_APPEND,
		EMIT_ENTRY
	} emit_t;

	typedef struct packed {
		logic        open_flag;
		logic [31:0] ins_final;
		logic [31:0] ins_first;
		logic [30:0] src_final;
		logic [30:0] src_first;
	} entry_t;

	typedef struct packed {
		logic  load;
		logic  append;
		logic  rd_last;
		logic  srch_init;
		logic  srch_rd;
		logic  srch_lo;
		logic  srch_hi;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic full;
		logic empty;
		logic off_gt_run;
		logic closed;
		logic below;
		logic above;
		logic srch_more;
	} sts_t;

endpackage

// ===== rtl/edit_list_offset_lookup.sv =====
// top level of the edit list offset lookup
// An append word is loaded in ST_IDLE and emits its result from ST_DECODE; a find word
// runs a binary search over the edit table, where each halving step costs one registered
// table read and one compare.
// busy is high from the accepted word until its result is registered; done then
// pulses for one cycle with the result, and a new word may be started in that
// same cycle. The result cannot be held off, so it must be captured when done is high.
module edit_list_offset_lookup #(
	parameter int MAX_EDITS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [30:0] range_first,
	input  logic [30:0] range_final,
	input  logic        open_ended,
	input  logic [31:0] query_offset,
	output logic        done,
	output logic [1:0]  status,
	output logic [7:0]  edit_index,
	output logic [30:0] edit_first,
	output logic [30:0] edit_final,
	output logic [31:0] insert_first,
	output logic        is_open,
	output logic [31:0] total_frames
);

	import elol_pkg::*;

	cmd_t cmd;
	sts_t sts;

	elol_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	elol_dp #(
		.MAX_EDITS (MAX_EDITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.range_first  (range_first),
		.range_final  (range_final),
		.open_ended   (open_ended),
		.query_offset (query_offset),
		.done         (done),
		.status       (status),
		.edit_index   (edit_index),
		.edit_first   (edit_first),
		.edit_final   (edit_final),
		.insert_first (insert_first),
		.is_open      (is_open),
		.total_frames (total_frames)
	);

`ifndef ASSERT_OFF
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a word in progress");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STATUS_OK || status == STATUS_MISS || status == STATUS_FULL))
		else $error("undefined status code");
`endif

endmodule

// ===== rtl/elol_ram.sv =====
// generic single write port ram with registered read
module elol_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/elol_ctrl.sv =====
// controller state machine for append and binary-search find
module elol_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  elol_pkg::sts_t sts,
	output elol_pkg::cmd_t cmd
);

	import elol_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.mode == MODE_APPEND || sts.empty) begin
					state_d = ST_IDLE;
				end else if (sts.off_gt_run) begin
					state_d = sts.closed ? ST_ENTRY : ST_IDLE;
				end else begin
					state_d = ST_LAST;
				end
			end
			ST_ENTRY: begin
				state_d = ST_IDLE;
			end
			ST_LAST: begin
				state_d = sts.below ? ST_IDLE : ST_SRCH_RD;
			end
			ST_SRCH_RD: begin
				state_d = sts.srch_more ? ST_SRCH_CMP : ST_IDLE;
			end
			ST_SRCH_CMP: begin
				state_d = (sts.below || sts.above) ? ST_SRCH_RD : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.emit = EMIT_NONE;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_DECODE: begin
				if (sts.mode == MODE_APPEND) begin
					if (sts.full) begin
						cmd.emit = EMIT_FULL;
					end else begin
						cmd.append = 1'b1;
						cmd.emit   = EMIT_APPEND;
					end
				end else if (sts.empty) begin
					cmd.emit = EMIT_MISS;
				end else if (sts.off_gt_run) begin
					if (sts.closed) begin
						cmd.rd_last = 1'b1;
					end else begin
						cmd.emit = EMIT_MISS;
					end
				end else begin
					cmd.rd_last = 1'b1;
				end
			end
			ST_ENTRY: begin
				cmd.emit = EMIT_ENTRY;
			end
			ST_LAST: begin
				if (sts.below) begin
					cmd.emit = EMIT_MISS;
				end else begin
					cmd.srch_init = 1'b1;
				end
			end
			ST_SRCH_RD: begin
				if (sts.srch_more) begin
					cmd.srch_rd = 1'b1;
				end else begin
					cmd.emit = EMIT_MISS;
				end
			end
			ST_SRCH_CMP: begin
				if (sts.below) begin
					cmd.srch_lo = 1'b1;
				end else if (sts.above) begin
					cmd.srch_hi = 1'b1;
				end else begin
					cmd.emit = EMIT_ENTRY;
				end
			end
			default: begin
				cmd.emit = EMIT_NONE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

`ifndef ASSERT_OFF
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH_CMP |-> $past(state_q) == ST_SRCH_RD)
		else $error("compare without a preceding read");
	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit != EMIT_NONE |=> state_q == ST_IDLE)
		else $error("controller did not return to idle after a result");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_DECODE)
		else $error("load did not start decode");
`endif

endmodule

// ===== rtl/elol_dp.sv =====
// datapath: edit table, offset chain and search bounds
module elol_dp #(
	parameter int MAX_EDITS = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  elol_pkg::cmd_t cmd,
	output elol_pkg::sts_t sts,
	input  logic           mode,
	input  logic [30:0]    range_first,
	input  logic [30:0]    range_final,
	input  logic           open_ended,
	input  logic [31:0]    query_offset,
	output logic           done,
	output logic [1:0]     status,
	output logic [7:0]     edit_index,
	output logic [30:0]    edit_first,
	output logic [30:0]    edit_final,
	output logic [31:0]    insert_first,
	output logic           is_open,
	output logic [31:0]    total_frames
);

	import elol_pkg::*;

	localparam int IDX_W = $clog2(MAX_EDITS);
	localparam int CNT_W = $clog2(MAX_EDITS + 1);
	localparam int EXT_W = IDX_W + 8;

	logic             mode_q;
	logic [30:0]      first_q;
	logic [30:0]      final_q;
	logic             open_q;
	logic [31:0]      off_q;

	logic [CNT_W-1:0] count_q;
	logic [31:0]      run_q;
	logic [IDX_W-1:0] last_q;
	logic             closed_q;
	logic [IDX_W:0]   lo_q;
	logic [IDX_W:0]   hi1_q;
	logic [IDX_W-1:0] rd_idx_q;

	logic             done_q;
	logic [1:0]       status_q;
	logic [7:0]       edit_index_q;
	logic [30:0]      edit_first_q;
	logic [30:0]      edit_final_q;
	logic [31:0]      insert_first_q;
	logic             is_open_q;
	logic [31:0]      total_frames_q;

	logic [31:0]      size;
	logic [31:0]      ins_first_new;
	logic [31:0]      ins_final_new;
	logic [31:0]      run_next;
	logic [IDX_W-1:0] app_idx;
	logic [IDX_W:0]   span;
	logic [IDX_W:0]   mid_ext;
	logic [IDX_W-1:0] mid;
	logic [IDX_W-1:0] raddr;
	logic             re;
	entry_t           wentry;
	entry_t           rentry;
	logic [EXT_W-1:0] app_idx_ext;
	logic [EXT_W-1:0] rd_idx_ext;

	// append arithmetic
	assign size          = {1'b0, final_q} - {1'b0, first_q} + 32'd1;
	assign ins_first_new = closed_q ? 32'd0 : run_q;
	assign ins_final_new = closed_q ? 32'd0 : (open_q ? OFFSET_MAX : run_q + size - 32'd1);
	assign run_next      = (!closed_q && !open_q) ? run_q + size : run_q;
	assign app_idx       = count_q[IDX_W-1:0];

	assign wentry.open_flag = open_q;
	assign wentry.ins_final = ins_final_new;
	assign wentry.ins_first = ins_first_new;
	assign wentry.src_final = open_q ? FRAME_MAX : final_q;
	assign wentry.src_first = first_q;

	// search midpoint, valid while lo < hi1
	assign span    = hi1_q - lo_q - 1'b1;
	assign mid_ext = lo_q + (span >> 1);
	assign mid     = mid_ext[IDX_W-1:0];

	assign re    = cmd.rd_last || cmd.srch_rd;
	assign raddr = cmd.rd_last ? last_q : mid;

	elol_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_EDITS)
	) u_table (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (app_idx),
		.wdata (wentry),
		.re    (re),
		.raddr (raddr),
		.rdata (rentry)
	);

	assign app_idx_ext = {8'd0, app_idx};
	assign rd_idx_ext  = {8'd0, rd_idx_q};

	assign sts.mode       = mode_q;
	assign sts.full       = (count_q == CNT_W'(MAX_EDITS));
	assign sts.empty      = (count_q == '0);
	assign sts.off_gt_run = (off_q > run_q);
	assign sts.closed     = closed_q;
	assign sts.below      = (rentry.ins_final < off_q);
	assign sts.above      = (rentry.ins_first > off_q);
	assign sts.srch_more  = (lo_q < hi1_q);

	// held word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			first_q <= range_first;
			final_q <= range_final;
			open_q  <= open_ended;
			off_q   <= query_offset;
		end
		if (re) begin
			rd_idx_q <= raddr;
		end
	end

	// table bookkeeping and search bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			run_q    <= '0;
			last_q   <= '0;
			closed_q <= 1'b0;
			lo_q     <= '0;
			hi1_q    <= '0;
		end else begin
			if (cmd.append) begin
				count_q <= count_q + 1'b1;
				run_q   <= run_next;
				if (!closed_q) begin
					last_q <= app_idx;
					if (open_q) begin
						closed_q <= 1'b1;
					end
				end
			end
			if (cmd.srch_init) begin
				lo_q  <= '0;
				hi1_q <= {1'b0, last_q} + 1'b1;
			end
			if (cmd.srch_lo) begin
				lo_q <= {1'b0, rd_idx_q} + 1'b1;
			end
			if (cmd.srch_hi) begin
				hi1_q <= {1'b0, rd_idx_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.emit != EMIT_NONE);
		end
	end

	// result word
	always_ff @(posedge clk) begin
		case (cmd.emit)
			EMIT_FULL, EMIT_MISS: begin
				status_q       <= (cmd.emit == EMIT_FULL) ? STATUS_FULL : STATUS_MISS;
				edit_index_q   <= '0;
				edit_first_q   <= '0;
				edit_final_q   <= '0;
				insert_first_q <= '0;
				is_open_q      <= 1'b0;
				total_frames_q <= run_q;
			end
			EMIT_APPEND: begin
				status_q       <= STATUS_OK;
				edit_index_q   <= app_idx_ext[7:0];
				edit_first_q   <= wentry.src_first;
				edit_final_q   <= wentry.src_final;
				insert_first_q <= ins_first_new;
				is_open_q      <= open_q;
				total_frames_q <= run_next;
			end
			EMIT_ENTRY: begin
				status_q       <= STATUS_OK;
				edit_index_q   <= rd_idx_ext[7:0];
				edit_first_q   <= rentry.src_first;
				edit_final_q   <= rentry.src_final;
				insert_first_q <= rentry.ins_first;
				is_open_q      <= rentry.open_flag;
				total_frames_q <= run_q;
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	assign done         = done_q;
	assign status       = status_q;
	assign edit_index   = edit_index_q;
	assign edit_first   = edit_first_q;
	assign edit_final   = edit_final_q;
	assign insert_first = insert_first_q;
	assign is_open      = is_open_q;
	assign total_frames = total_frames_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_EDITS))
		else $error("edit count beyond table depth");
	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi1_q)
		else $error("search bounds crossed");
	a_last_written: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.empty |-> {1'b0, last_q} < count_q)
		else $error("last indexed edit not in table");
`endif

endmodule
